>>> sv/system_control_register_block_core_assert.svh
// ----------------------------------------------------------------------------
// System control register block - assertion macros
// Shared property forms for the checks inside the core's modules.
// ----------------------------------------------------------------------------
`ifndef SYSTEM_CONTROL_REGISTER_BLOCK_CORE_ASSERT_SVH
`define SYSTEM_CONTROL_REGISTER_BLOCK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SCRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scrb: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SCRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scrb: next-cycle check failed");

`endif

>>> sv/scrb_pkg.sv
// ----------------------------------------------------------------------------
// System control register block - package
// Register offsets, part numbers, access classification and shared types.
// ----------------------------------------------------------------------------
package scrb_pkg;

  localparam int NumOscClocks = 4;
  localparam int NumLeds      = 8;
  localparam int QueueDepth   = 2;
  localparam int PaddrW       = 5;

  localparam logic [11:0] PartA = 12'h524;
  localparam logic [11:0] PartB = 12'h547;
  localparam logic [11:0] PartC = 12'h536;

  localparam logic [11:0] OffCfg0    = 12'h000;
  localparam logic [11:0] OffCfg1    = 12'h004;
  localparam logic [11:0] OffCfg2    = 12'h008;
  localparam logic [11:0] OffCfg3    = 12'h00c;
  localparam logic [11:0] OffCfg4    = 12'h010;
  localparam logic [11:0] OffCfg5    = 12'h014;
  localparam logic [11:0] OffCfg6    = 12'h018;
  localparam logic [11:0] OffCfg7    = 12'h01c;
  localparam logic [11:0] OffChRdata = 12'h0a0;
  localparam logic [11:0] OffChOdata = 12'h0a4;
  localparam logic [11:0] OffChCtrl  = 12'h0a8;
  localparam logic [11:0] OffChStat  = 12'h0ac;
  localparam logic [11:0] OffDll     = 12'h100;
  localparam logic [11:0] OffAuxId   = 12'hff8;
  localparam logic [11:0] OffId      = 12'hffc;

  localparam logic [31:0] ChCtrlReset   = 32'h0010_0000;
  localparam logic [31:0] ChCtrlClrMask = 32'hbc0f_f000;
  localparam logic [23:0] DllFixedBits  = 24'hff_0001;
  localparam logic [5:0]  FnOscClock    = 6'd1;
  localparam logic [2:0]  OscCountReset = 3'd3;

  typedef enum logic [3:0] {
    SEL_CFG0, SEL_CFG1, SEL_CFG2, SEL_CFG3, SEL_CFG4, SEL_CFG5, SEL_CFG6, SEL_CFG7,
    SEL_CH_RDATA, SEL_CH_ODATA, SEL_CH_CTRL, SEL_CH_STAT, SEL_DLL, SEL_AUX_ID,
    SEL_ID, SEL_NONE
  } reg_sel_t;

  typedef enum logic [2:0] {
    CFG_BOARD_ID, CFG_AUX_ID, CFG_CFG4_VALUE, CFG_CFG0_RESET, CFG_OSC_COUNT,
    CFG_OSC0_RESET, CFG_OSC1_RESET, CFG_OSC2_RESET
  } cfg_idx_t;

  // One classified bus transaction as it sits in the queue.
  typedef struct packed {
    logic        wr;
    reg_sel_t    sel;
    logic        bad;
    logic [31:0] data;
  } acc_t;

  typedef struct packed {
    logic        en;
    cfg_idx_t    idx;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

>>> sv/scrb_front.sv
// ----------------------------------------------------------------------------
// System control register block - front end
// Accepts transactions, decodes the offset, flags absent regs and bad writes.
// ----------------------------------------------------------------------------
module scrb_front (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   opcode,
  input  logic [11:0]            byte_offset,
  input  logic [31:0]            write_data,
  input  logic [11:0]            part_number,
  input  logic                   q_full,
  output logic                   q_push,
  output scrb_pkg::acc_t         q_entry
);
  import scrb_pkg::*;

  reg_sel_t sel;
  logic     bad;
  logic     has_cfg2_5;
  logic     has_cfg6;
  logic     has_cfg7;

  assign has_cfg2_5 = (part_number == PartA) || (part_number == PartB) ||
                      (part_number == PartC);
  assign has_cfg6   = (part_number == PartA) || (part_number == PartC);
  assign has_cfg7   = (part_number == PartC);

  always_comb begin
    unique case (byte_offset)
      OffCfg0:    sel = SEL_CFG0;
      OffCfg1:    sel = SEL_CFG1;
      OffCfg2:    sel = SEL_CFG2;
      OffCfg3:    sel = SEL_CFG3;
      OffCfg4:    sel = SEL_CFG4;
      OffCfg5:    sel = SEL_CFG5;
      OffCfg6:    sel = SEL_CFG6;
      OffCfg7:    sel = SEL_CFG7;
      OffChRdata: sel = SEL_CH_RDATA;
      OffChOdata: sel = SEL_CH_ODATA;
      OffChCtrl:  sel = SEL_CH_CTRL;
      OffChStat:  sel = SEL_CH_STAT;
      OffDll:     sel = SEL_DLL;
      OffAuxId:   sel = SEL_AUX_ID;
      OffId:      sel = SEL_ID;
      default:    sel = SEL_NONE;
    endcase
  end

  always_comb begin
    unique case (sel) inside
      SEL_NONE:                                        bad = 1'b1;
      SEL_CFG2, SEL_CFG5:                              bad = !has_cfg2_5;
      // cfg3 only exists on parts without cfg2/cfg5, and never takes writes
      SEL_CFG3:                                        bad = opcode || has_cfg2_5;
      SEL_CFG6:                                        bad = !has_cfg6;
      SEL_CFG7:                                        bad = !has_cfg7;
      SEL_CFG4, SEL_CH_RDATA, SEL_CH_STAT, SEL_AUX_ID,
      SEL_ID:                                          bad = opcode;
      default:                                         bad = 1'b0;
    endcase
  end

  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_entry.wr    = opcode;
  assign q_entry.sel   = sel;
  assign q_entry.bad   = bad;
  assign q_entry.data  = write_data;

endmodule

>>> sv/scrb_queue.sv
// ----------------------------------------------------------------------------
// System control register block - transaction queue
// Short FIFO of classified transactions between the front and back ends.
// ----------------------------------------------------------------------------
`include "system_control_register_block_core_assert.svh"

module scrb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scrb_pkg::acc_t push_entry,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output scrb_pkg::acc_t head
);
  import scrb_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  acc_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full      = (count == CntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  `SCRB_ASSERT_NEXT(a_q_count_up, clk, rst, push && !pop, count == $past(count) + CntW'(1))
  `SCRB_ASSERT_NEXT(a_q_count_dn, clk, rst, pop && !push, count == $past(count) - CntW'(1))
  `SCRB_ASSERT_IMPL(a_q_no_underflow, clk, rst, pop, count != '0)

endmodule

>>> sv/scrb_back.sv
// ----------------------------------------------------------------------------
// System control register block - back end
// Holds the register state and straps, executes one queued transaction per
// cycle while the output register is empty or read, serves the strap port.
// ----------------------------------------------------------------------------
`include "system_control_register_block_core_assert.svh"

module scrb_back #(
  parameter int NUM_OSC_CLOCKS = scrb_pkg::NumOscClocks,
  parameter int NUM_LEDS       = scrb_pkg::NumLeds
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  scrb_pkg::acc_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         read_data,
  output logic                offset_error,
  output logic                remap_level,
  output logic [7:0]          led_levels,
  input  scrb_pkg::cfg_wr_t   cfg_wr,
  input  scrb_pkg::cfg_idx_t  cfg_rd_idx,
  output logic [31:0]         cfg_rd_data,
  output logic [11:0]         part_number
);
  import scrb_pkg::*;

  localparam int OscIdxW = (NUM_OSC_CLOCKS > 1) ? $clog2(NUM_OSC_CLOCKS) : 1;

  // straps
  logic [31:0] board_id_word;
  logic [31:0] aux_id_word;
  logic [31:0] cfg4_value;
  logic [31:0] cfg0_reset_value;
  logic [2:0]  osc_count;
  logic [31:0] osc_rst [3];

  // register state
  logic [31:0] ctrl_reg0, ctrl_reg1, ctrl_reg2, ctrl_reg5, ctrl_reg6, ctrl_reg7;
  logic [31:0] ch_rdata, ch_odata, ch_ctrl;
  logic [1:0]  ch_stat;
  logic [7:0]  lock_mask;
  logic [31:0] osc_words [NUM_OSC_CLOCKS];

  logic [31:0] ctrl_reg0_next, ctrl_reg1_next, ctrl_reg2_next, ctrl_reg5_next;
  logic [31:0] ctrl_reg6_next, ctrl_reg7_next;
  logic [31:0] ch_rdata_next, ch_odata_next, ch_ctrl_next;
  logic [1:0]  ch_stat_next;
  logic [7:0]  lock_mask_next;

  logic        exec;
  logic [31:0] rdata;
  logic        osc_we;
  logic [11:0] dev;
  logic [5:0]  fn;
  logic [4:0]  osc_limit;
  logic        dev_ok;
  logic [7:0]  leds;
  logic [1:0]  osc_cfg_sel;
  logic        osc_cfg_hit;

  assign part_number = board_id_word[15:4];
  assign exec        = q_valid && (!out_valid || out_ready);
  assign q_pop       = exec;

  // channel decode works on the written value
  assign dev       = q_head.data[11:0];
  assign fn        = q_head.data[25:20];
  assign osc_limit = (5'(osc_count) > 5'(NUM_OSC_CLOCKS)) ? 5'(NUM_OSC_CLOCKS)
                                                          : 5'(osc_count);
  assign dev_ok    = (fn == FnOscClock) && (dev < 12'(osc_limit));

  always_comb begin
    ctrl_reg0_next = ctrl_reg0;
    ctrl_reg1_next = ctrl_reg1;
    ctrl_reg2_next = ctrl_reg2;
    ctrl_reg5_next = ctrl_reg5;
    ctrl_reg6_next = ctrl_reg6;
    ctrl_reg7_next = ctrl_reg7;
    ch_rdata_next  = ch_rdata;
    ch_odata_next  = ch_odata;
    ch_ctrl_next   = ch_ctrl;
    ch_stat_next   = ch_stat;
    lock_mask_next = lock_mask;
    osc_we         = 1'b0;
    rdata          = '0;
    if (!q_head.bad) begin
      if (q_head.wr) begin
        unique case (q_head.sel)
          SEL_CFG0:     ctrl_reg0_next = q_head.data;
          SEL_CFG1:     ctrl_reg1_next = q_head.data;
          SEL_CFG2:     ctrl_reg2_next = q_head.data;
          SEL_CFG5:     ctrl_reg5_next = q_head.data;
          SEL_CFG6:     ctrl_reg6_next = q_head.data;
          SEL_CFG7:     ctrl_reg7_next = q_head.data;
          SEL_CH_ODATA: ch_odata_next  = q_head.data;
          SEL_CH_CTRL: begin
            ch_ctrl_next = q_head.data & ~ChCtrlClrMask;
            ch_stat_next = 2'b00;
            if (q_head.data[31]) begin
              ch_stat_next[0] = 1'b1;
              if (!dev_ok) begin
                ch_stat_next[1] = 1'b1;
              end else if (q_head.data[30]) begin
                osc_we = 1'b1;
              end else begin
                ch_rdata_next = osc_words[dev[OscIdxW-1:0]];
              end
            end
          end
          SEL_DLL:      lock_mask_next = q_head.data[31:24];
          default:      ;
        endcase
      end else begin
        unique case (q_head.sel)
          SEL_CFG0:     rdata = ctrl_reg0;
          SEL_CFG1:     rdata = ctrl_reg1;
          SEL_CFG2:     rdata = ctrl_reg2;
          SEL_CFG4:     rdata = cfg4_value;
          SEL_CFG5:     rdata = ctrl_reg5;
          SEL_CFG6:     rdata = ctrl_reg6;
          SEL_CFG7:     rdata = ctrl_reg7;
          SEL_CH_RDATA: rdata = ch_rdata;
          SEL_CH_ODATA: rdata = ch_odata;
          SEL_CH_CTRL:  rdata = ch_ctrl;
          SEL_CH_STAT:  rdata = {30'd0, ch_stat};
          SEL_DLL:      rdata = {lock_mask, DllFixedBits};
          SEL_AUX_ID:   rdata = aux_id_word;
          SEL_ID:       rdata = board_id_word;
          default:      rdata = '0;
        endcase
      end
    end
  end

  // LED and remap lines follow the state after this transaction
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      leds[i] = (i < NUM_LEDS) ? ctrl_reg1_next[i] : 1'b0;
    end
  end

  assign osc_cfg_hit = (cfg_wr.idx == CFG_OSC0_RESET) || (cfg_wr.idx == CFG_OSC1_RESET) ||
                       (cfg_wr.idx == CFG_OSC2_RESET);
  assign osc_cfg_sel = 2'(cfg_wr.idx - CFG_OSC0_RESET);

  // straps
  always_ff @(posedge clk) begin
    if (rst) begin
      board_id_word    <= '0;
      aux_id_word      <= '0;
      cfg4_value       <= '0;
      cfg0_reset_value <= '0;
      osc_count        <= OscCountReset;
      for (int i = 0; i < 3; i++) begin
        osc_rst[i] <= '0;
      end
    end else if (cfg_wr.en) begin
      unique case (cfg_wr.idx)
        CFG_BOARD_ID:   board_id_word    <= cfg_wr.data;
        CFG_AUX_ID:     aux_id_word      <= cfg_wr.data;
        CFG_CFG4_VALUE: cfg4_value       <= cfg_wr.data;
        CFG_CFG0_RESET: cfg0_reset_value <= cfg_wr.data;
        CFG_OSC_COUNT:  osc_count        <= cfg_wr.data[2:0];
        CFG_OSC0_RESET: osc_rst[0]       <= cfg_wr.data;
        CFG_OSC1_RESET: osc_rst[1]       <= cfg_wr.data;
        CFG_OSC2_RESET: osc_rst[2]       <= cfg_wr.data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_reg0 <= '0;
      ctrl_reg1 <= '0;
      ctrl_reg2 <= '0;
      ctrl_reg5 <= '0;
      ctrl_reg6 <= '0;
      ctrl_reg7 <= '0;
      ch_rdata  <= '0;
      ch_odata  <= '0;
      ch_ctrl   <= ChCtrlReset;
      ch_stat   <= '0;
      lock_mask <= '1;
    end else if (exec) begin
      ctrl_reg0 <= ctrl_reg0_next;
      ctrl_reg1 <= ctrl_reg1_next;
      ctrl_reg2 <= ctrl_reg2_next;
      ctrl_reg5 <= ctrl_reg5_next;
      ctrl_reg6 <= ctrl_reg6_next;
      ctrl_reg7 <= ctrl_reg7_next;
      ch_rdata  <= ch_rdata_next;
      ch_odata  <= ch_odata_next;
      ch_ctrl   <= ch_ctrl_next;
      ch_stat   <= ch_stat_next;
      lock_mask <= lock_mask_next;
    end else if (cfg_wr.en && cfg_wr.idx == CFG_CFG0_RESET) begin
      // strap takes effect at once
      ctrl_reg0 <= cfg_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_OSC_CLOCKS; i++) begin
      if (rst) begin
        osc_words[i] <= '0;
      end else if (exec && osc_we && int'(dev) == i) begin
        osc_words[i] <= ch_odata;
      end else if (!exec && cfg_wr.en && osc_cfg_hit && int'(osc_cfg_sel) == i) begin
        osc_words[i] <= cfg_wr.data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      read_data    <= rdata;
      offset_error <= q_head.bad;
      remap_level  <= (part_number != PartC) ? ctrl_reg0_next[0] : 1'b0;
      led_levels   <= (part_number != PartC) ? leds : 8'd0;
    end
  end

  always_comb begin
    unique case (cfg_rd_idx)
      CFG_BOARD_ID:   cfg_rd_data = board_id_word;
      CFG_AUX_ID:     cfg_rd_data = aux_id_word;
      CFG_CFG4_VALUE: cfg_rd_data = cfg4_value;
      CFG_CFG0_RESET: cfg_rd_data = cfg0_reset_value;
      CFG_OSC_COUNT:  cfg_rd_data = {29'd0, osc_count};
      CFG_OSC0_RESET: cfg_rd_data = osc_rst[0];
      CFG_OSC1_RESET: cfg_rd_data = osc_rst[1];
      CFG_OSC2_RESET: cfg_rd_data = osc_rst[2];
      default:        cfg_rd_data = '0;
    endcase
  end

  `SCRB_ASSERT_IMPL(a_ch_err_has_done, clk, rst, ch_stat[1], ch_stat[0])
  `SCRB_ASSERT_IMPL(a_ch_ctrl_clear, clk, rst, 1'b1, (ch_ctrl & ChCtrlClrMask) == 32'd0)
  `SCRB_ASSERT_IMPL(a_bad_reads_zero, clk, rst, out_valid && offset_error, read_data == 32'd0)

endmodule

>>> sv/system_control_register_block_core.sv
// ----------------------------------------------------------------------------
// System control register block - top level
// Bus transaction channel, result channel and strap configuration port.
// ----------------------------------------------------------------------------
// Takes one register transaction per cycle while the queue has room and
// returns one result for each, in order. The front end decodes the offset
// against the part number from the ID strap and drops the transaction into a
// two-entry queue; the back end executes the queue head against the register
// state and loads the output register, so a stalled output costs throughput
// only once the queue fills. Sustained rate is one transaction per cycle while
// results are taken, set by the single execute step in the back end. Straps
// sit on the APB port at 4-byte spacing and take effect at once.
module system_control_register_block_core #(
  parameter int NUM_OSC_CLOCKS = scrb_pkg::NumOscClocks,
  parameter int NUM_LEDS       = scrb_pkg::NumLeds
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [11:0]                 byte_offset,
  input  logic [31:0]                 write_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 read_data,
  output logic                        offset_error,
  output logic                        remap_level,
  output logic [7:0]                  led_levels,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scrb_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import scrb_pkg::*;

  acc_t        q_entry;
  acc_t        q_head;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_valid;
  logic [11:0] part_number;
  cfg_wr_t     cfg_wr;
  cfg_idx_t    cfg_rd_idx;

  assign pready      = 1'b1;
  assign cfg_rd_idx  = cfg_idx_t'(paddr[PaddrW-1:2]);
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = cfg_rd_idx;
  assign cfg_wr.data = pwdata;

  scrb_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .byte_offset (byte_offset),
    .write_data  (write_data),
    .part_number (part_number),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  scrb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  scrb_back #(
    .NUM_OSC_CLOCKS (NUM_OSC_CLOCKS),
    .NUM_LEDS       (NUM_LEDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .offset_error (offset_error),
    .remap_level  (remap_level),
    .led_levels   (led_levels),
    .cfg_wr       (cfg_wr),
    .cfg_rd_idx   (cfg_rd_idx),
    .cfg_rd_data  (prdata),
    .part_number  (part_number)
  );

endmodule
